// ----- rtl/gpio_pin_controller_defines.svh -----
// ---------------------------------------------------------------------------
// gpio_pin_controller assertion macros
// Shared property wrappers for the pin controller checks.
// ---------------------------------------------------------------------------
`ifndef GPIO_PIN_CONTROLLER_DEFINES_SVH
`define GPIO_PIN_CONTROLLER_DEFINES_SVH

// Same-cycle implication, masked while reset is held.
`define GPC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked while reset is held.
`define GPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/gpc_pkg.sv -----
// ---------------------------------------------------------------------------
// gpc_pkg
// Types and fixed constants of the pin controller: register map, codes.
// ---------------------------------------------------------------------------
`default_nettype none

package gpc_pkg;

    localparam int PORT_PINS    = 54;  // width of every per-pin port
    localparam int SEL_WORDS    = 6;
    localparam int PINS_PER_SEL = 10;
    localparam int MODE_BITS    = 3;
    localparam int SEL_BITS     = PINS_PER_SEL * MODE_BITS;
    localparam int SEL_PINS     = SEL_WORDS * PINS_PER_SEL;

    // Byte offsets of the register banks
    localparam logic [7:0] OFS_SET0 = 8'h1c;
    localparam logic [7:0] OFS_CLR0 = 8'h28;
    localparam logic [7:0] OFS_LEV0 = 8'h34;
    localparam logic [7:0] OFS_PUD  = 8'h94;

    // Word addresses
    localparam logic [5:0] ADDR_SEL_LAST = 6'(SEL_WORDS - 1);
    localparam logic [5:0] ADDR_SET0     = OFS_SET0[7:2];
    localparam logic [5:0] ADDR_SET1     = ADDR_SET0 + 6'd1;
    localparam logic [5:0] ADDR_CLR0     = OFS_CLR0[7:2];
    localparam logic [5:0] ADDR_CLR1     = ADDR_CLR0 + 6'd1;
    localparam logic [5:0] ADDR_LEV0     = OFS_LEV0[7:2];
    localparam logic [5:0] ADDR_LEV1     = ADDR_LEV0 + 6'd1;
    localparam logic [5:0] ADDR_PUD      = OFS_PUD[7:2];
    localparam logic [5:0] ADDR_PUDCLK0  = ADDR_PUD + 6'd1;
    localparam logic [5:0] ADDR_PUDCLK1  = ADDR_PUD + 6'd2;

    localparam logic [MODE_BITS-1:0] MODE_OUTPUT = 3'd1;

    typedef enum logic [1:0] {
        PULL_OFF      = 2'd0,
        PULL_DOWN     = 2'd1,
        PULL_UP       = 2'd2,
        PULL_RESERVED = 2'd3
    } pull_code_t;

    // One bus access as staged in the input register
    typedef struct packed {
        logic                 wr;
        logic [5:0]           addr;
        logic [31:0]          data;
        logic [PORT_PINS-1:0] levels;
    } gpc_access_t;

    // Pin-facing view of the controller state
    typedef struct packed {
        logic [PORT_PINS-1:0] level;
        logic [PORT_PINS-1:0] enable;
        logic [PORT_PINS-1:0] pull_up;
        logic [PORT_PINS-1:0] pull_down;
    } gpc_pins_t;

endpackage

`default_nettype wire

// ----- rtl/gpc_regs.sv -----
// ---------------------------------------------------------------------------
// gpc_regs
// Register file of the pin controller: decode, read mux and state update.
// ---------------------------------------------------------------------------
`default_nettype none

module gpc_regs #(
    parameter int NUM_PINS = 54
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  gpc_pkg::gpc_access_t acc,
    input  logic                commit,
    output logic [31:0]         rd_data,
    output gpc_pkg::gpc_pins_t  pins_next
);

    import gpc_pkg::*;

    localparam logic [63:0] PIN_MASK64 =
        (NUM_PINS >= 64) ? {64{1'b1}} : ((64'd1 << NUM_PINS) - 64'd1);

    logic [SEL_BITS-1:0] fsel_reg  [SEL_WORDS];
    logic [SEL_BITS-1:0] fsel_next [SEL_WORDS];
    logic [NUM_PINS-1:0] latch_reg, latch_next;
    logic [NUM_PINS-1:0] pu_reg, pu_next;
    logic [NUM_PINS-1:0] pd_reg, pd_next;
    pull_code_t          pcode_reg, pcode_next;

    logic                hi;
    logic [63:0]         bank64;
    logic [NUM_PINS-1:0] bank;
    logic [63:0]         lev64;
    logic [2:0]          sel_idx;
    logic [31:0]         rd;
    logic [NUM_PINS-1:0] en;

    // Bits of select word w that belong to existing pins
    function automatic logic [SEL_BITS-1:0] sel_mask(input logic [2:0] w);
        logic [SEL_BITS-1:0] m;
        m = '0;
        for (int f = 0; f < PINS_PER_SEL; f++) begin
            if ((int'(w) * PINS_PER_SEL + f) < NUM_PINS) begin
                m[f*MODE_BITS +: MODE_BITS] = '1;
            end
        end
        return m;
    endfunction

    function automatic logic [63:0] widen(input logic [NUM_PINS-1:0] x);
        logic [63:0] r;
        r = '0;
        r[NUM_PINS-1:0] = x;
        return r;
    endfunction

    assign hi = (acc.addr == ADDR_SET1) || (acc.addr == ADDR_CLR1) ||
                (acc.addr == ADDR_LEV1) || (acc.addr == ADDR_PUDCLK1);
    assign bank64  = hi ? {acc.data, 32'h0} : {32'h0, acc.data};
    assign bank    = bank64[NUM_PINS-1:0];
    assign lev64   = {{(64 - PORT_PINS){1'b0}}, acc.levels} & PIN_MASK64;
    assign sel_idx = acc.addr[2:0];

    always_comb begin
        fsel_next  = fsel_reg;
        latch_next = latch_reg;
        pu_next    = pu_reg;
        pd_next    = pd_reg;
        pcode_next = pcode_reg;
        rd         = '0;
        if (acc.addr <= ADDR_SEL_LAST) begin
            if (acc.wr) begin
                fsel_next[sel_idx] = acc.data[SEL_BITS-1:0] & sel_mask(sel_idx);
            end else begin
                rd = {{(32 - SEL_BITS){1'b0}}, fsel_reg[sel_idx]};
            end
        end else begin
            case (acc.addr)
                ADDR_SET0, ADDR_SET1: begin
                    if (acc.wr) latch_next = latch_reg | bank;
                end
                ADDR_CLR0, ADDR_CLR1: begin
                    if (acc.wr) latch_next = latch_reg & ~bank;
                end
                ADDR_LEV0, ADDR_LEV1: begin
                    if (!acc.wr) rd = hi ? lev64[63:32] : lev64[31:0];
                end
                ADDR_PUD: begin
                    if (acc.wr) begin
                        pcode_next = pull_code_t'(acc.data[1:0]);
                    end else begin
                        rd = {30'h0, pcode_reg};
                    end
                end
                ADDR_PUDCLK0, ADDR_PUDCLK1: begin
                    if (acc.wr) begin
                        pu_next = pu_reg & ~bank;
                        pd_next = pd_reg & ~bank;
                        if (pcode_reg == PULL_UP) begin
                            pu_next = pu_next | bank;
                        end else if (pcode_reg == PULL_DOWN) begin
                            pd_next = pd_next | bank;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int w = 0; w < SEL_WORDS; w++) fsel_reg[w] <= '0;
            latch_reg <= '0;
            pu_reg    <= '0;
            pd_reg    <= '0;
            pcode_reg <= PULL_OFF;
        end else if (commit) begin
            fsel_reg  <= fsel_next;
            latch_reg <= latch_next;
            pu_reg    <= pu_next;
            pd_reg    <= pd_next;
            pcode_reg <= pcode_next;
        end
    end

    // Output enable: pins with a select field whose mode is output
    for (genvar p = 0; p < NUM_PINS; p++) begin : g_en
        if (p < SEL_PINS) begin : g_sel
            assign en[p] = (fsel_next[p / PINS_PER_SEL][(p % PINS_PER_SEL) * MODE_BITS +:
                            MODE_BITS] == MODE_OUTPUT);
        end else begin : g_nosel
            assign en[p] = 1'b0;
        end
    end

    logic [63:0] level64, en64, pu64, pd64;
    assign level64 = widen(latch_next);
    assign en64    = widen(en);
    assign pu64    = widen(pu_next);
    assign pd64    = widen(pd_next);

    assign pins_next.level     = level64[PORT_PINS-1:0];
    assign pins_next.enable    = en64[PORT_PINS-1:0];
    assign pins_next.pull_up   = pu64[PORT_PINS-1:0];
    assign pins_next.pull_down = pd64[PORT_PINS-1:0];
    assign rd_data             = acc.wr ? 32'h0 : rd;

endmodule

`default_nettype wire

// ----- rtl/gpio_pin_controller.sv -----
// ---------------------------------------------------------------------------
// gpio_pin_controller
// Pin controller behind a word-addressed register bus: function select,
// output set/clear, level readback and pull-resistor control.
// ---------------------------------------------------------------------------
//
//  Channel  Direction  Carries
//  s_*      in         one bus access per beat: cmd, word_addr, write_data,
//                      pin_levels
//  m_*      out        one result per beat: read_data and the pin state
//                      (drive level, drive enable, pull-up, pull-down)
//
//  Each beat waits in the input register; the register file is
//  updated and the result register loaded at the same edge, and a new
//  beat is taken every cycle while m_ready is high.
//  The read-modify-write of one register word is the only logic between
//  the two registers.
//  Reset (aresetn low at a clock edge) empties both stages and returns the
//  register file to all pins input, latch clear, pulls off.
//  While m_ready is low both stages fill and s_ready drops; no beat is lost.
// ---------------------------------------------------------------------------
`default_nettype none

`include "gpio_pin_controller_defines.svh"

module gpio_pin_controller #(
    parameter int NUM_PINS = 54
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_cmd,
    input  logic [5:0]                    s_word_addr,
    input  logic [31:0]                   s_write_data,
    input  logic [gpc_pkg::PORT_PINS-1:0] s_pin_levels,

    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [31:0]                   m_read_data,
    output logic [gpc_pkg::PORT_PINS-1:0] m_drive_level,
    output logic [gpc_pkg::PORT_PINS-1:0] m_drive_enable,
    output logic [gpc_pkg::PORT_PINS-1:0] m_pull_up_on,
    output logic [gpc_pkg::PORT_PINS-1:0] m_pull_down_on
);

    import gpc_pkg::*;

    // Input stage: holds the accepted beat until it can commit
    logic        in_valid_reg;
    gpc_access_t in_reg;

    // Result stage
    logic        out_valid_reg;
    logic [31:0] rd_reg;
    gpc_pins_t   pins_reg;

    logic        out_load;
    logic        commit;
    logic        s_fire;
    logic [31:0] rd_data;
    gpc_pins_t   pins_next;

    // Result register frees up when empty or being drained this cycle
    assign out_load = !out_valid_reg || m_ready;
    assign commit   = in_valid_reg && out_load;
    assign s_ready  = !in_valid_reg || out_load;
    assign s_fire   = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    // Capture the beat; payload needs no reset
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_reg.wr     <= s_cmd;
            in_reg.addr   <= s_word_addr;
            in_reg.data   <= s_write_data;
            in_reg.levels <= s_pin_levels;
        end
    end

    gpc_regs #(
        .NUM_PINS (NUM_PINS)
    ) u_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .acc       (in_reg),
        .commit    (commit),
        .rd_data   (rd_data),
        .pins_next (pins_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    // Result shows the state after the access has been applied
    always_ff @(posedge aclk) begin
        if (commit) begin
            rd_reg   <= rd_data;
            pins_reg <= pins_next;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_read_data    = rd_reg;
    assign m_drive_level  = pins_reg.level;
    assign m_drive_enable = pins_reg.enable;
    assign m_pull_up_on   = pins_reg.pull_up;
    assign m_pull_down_on = pins_reg.pull_down;

    // Checks
    `GPC_ASSERT_NEXT(a_write_reads_zero, aclk, aresetn, commit && in_reg.wr, m_read_data == 32'h0, "write beat returned nonzero read data")
    `GPC_ASSERT_NOW(a_pull_exclusive, aclk, aresetn, m_valid, (m_pull_up_on & m_pull_down_on) == '0, "pull-up and pull-down both on")
    `GPC_ASSERT_NOW(a_stall_full, aclk, aresetn, !s_ready, in_valid_reg && out_valid_reg && !m_ready, "input stalled with room in the pipeline")

endmodule

`default_nettype wire
